// ----- rtl/asop_pkg.sv -----
// Shared constants for the box-sphere overlap test pipeline.
// No dependencies; every other file in this folder imports it.
`default_nettype none

package asop_pkg;

    // Port field widths are fixed by the interface.
    localparam int FIELD_W         = 32;
    localparam int RADIUS_W        = 31;
    localparam int GAP_W           = 64;
    localparam int HALF_GAP_W      = 32;

    // Fixed-point format of all coordinates.
    localparam int FRAC_BITS       = 16;

    // Default internal coordinate width (valid range 16 to 32).
    localparam int COORD_WIDTH_DEF = 32;

    // Pipeline depth: per-axis stages, saturating sum stages, output compare stage.
    localparam int AXIS_STAGES     = 6;
    localparam int SUM_STAGES      = 2;
    localparam int PIPE_DEPTH      = AXIS_STAGES + SUM_STAGES + 1;

    // Radius square is formed in the second stage and carried to the compare stage.
    localparam int RSQ_DEPTH       = AXIS_STAGES + SUM_STAGES - 1;

endpackage

`default_nettype wire

// ----- rtl/asop_in_if.sv -----
// Input channel: one box and one sphere per beat, valid/ready handshake.
// Depends on asop_pkg for field widths.
`default_nettype none

interface asop_in_if import asop_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [FIELD_W-1:0]   box_center_x;
    logic [FIELD_W-1:0]   box_center_y;
    logic [FIELD_W-1:0]   box_center_z;
    logic [FIELD_W-1:0]   box_scale_x;
    logic [FIELD_W-1:0]   box_scale_y;
    logic [FIELD_W-1:0]   box_scale_z;
    logic [FIELD_W-1:0]   box_half_size;
    logic [FIELD_W-1:0]   sphere_center_x;
    logic [FIELD_W-1:0]   sphere_center_y;
    logic [FIELD_W-1:0]   sphere_center_z;
    logic [RADIUS_W-1:0]  sphere_radius;

    modport source (
        output valid, box_center_x, box_center_y, box_center_z,
        output box_scale_x, box_scale_y, box_scale_z, box_half_size,
        output sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
        input  ready
    );

    modport sink (
        input  valid, box_center_x, box_center_y, box_center_z,
        input  box_scale_x, box_scale_y, box_scale_z, box_half_size,
        input  sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/asop_out_if.sv -----
// Result channel: overlap flag and squared gap per beat, valid/ready handshake.
// Depends on asop_pkg for field widths.
`default_nettype none

interface asop_out_if import asop_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             overlaps;
    logic [GAP_W-1:0] squared_gap;

    modport source (
        output valid, overlaps, squared_gap,
        input  ready
    );

    modport sink (
        input  valid, overlaps, squared_gap,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/asop_axis.sv -----
// One axis of the box-sphere test: half-extent, box bounds, excess and its square.
// Six register stages, all advanced by a shared enable. Depends on asop_pkg.
`default_nettype none

module asop_axis import asop_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             adv,
    input  wire logic [W-1:0]     center,
    input  wire logic [W-1:0]     scale,
    input  wire logic [W-1:0]     size,
    input  wire logic [W-1:0]     point,
    output logic      [GAP_W-1:0] gap
);

    // Product, half-extent, bound and difference widths.
    localparam int PW = 2 * W;
    localparam int HW = PW - FRAC_BITS;
    localparam int BW = HW + 2;
    localparam int DW = BW + 1;

    // Stage 1: scale times size.
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic [W-1:0]         c1_reg;
    logic [W-1:0]         p1_reg;

    // Stage 2: magnitude with fraction bits dropped.
    logic [PW-1:0]        mag;
    logic [HW-1:0]        half_next;
    logic [HW-1:0]        half_reg;
    logic [W-1:0]         c2_reg;
    logic [W-1:0]         p2_reg;

    // Stage 3: box bounds on this axis, kept at full width.
    logic [BW-1:0]        c_ext;
    logic [BW-1:0]        half_ext;
    logic [BW-1:0]        lo_next;
    logic [BW-1:0]        hi_next;
    logic [BW-1:0]        lo_reg;
    logic [BW-1:0]        hi_reg;
    logic [W-1:0]         p3_reg;

    // Stage 4: distance below the low bound and above the high bound.
    logic [DW-1:0]        p_ext;
    logic [DW-1:0]        dlo_next;
    logic [DW-1:0]        dhi_next;
    logic [DW-1:0]        dlo_reg;
    logic [DW-1:0]        dhi_reg;

    // Stage 5: pick the positive excess and flag one too large to square.
    logic                 below;
    logic                 above;
    logic [DW-1:0]        e_sel;
    logic [GAP_W-1:0]     e_wide;
    logic [HALF_GAP_W-1:0] e_next;
    logic                 sat_next;
    logic [HALF_GAP_W-1:0] e_reg;
    logic                 sat_reg;

    // Stage 6: squared excess, saturated.
    logic [GAP_W-1:0]     gap_next;
    logic [GAP_W-1:0]     gap_reg;

    assign prod_next = PW'(signed'(scale)) * PW'(signed'(size));

    assign mag       = prod_reg[PW-1] ? (~prod_reg + 1'b1) : prod_reg;
    assign half_next = mag[PW-1:FRAC_BITS];

    assign c_ext    = {{(BW-W){c2_reg[W-1]}}, c2_reg};
    assign half_ext = {2'b00, half_reg};
    assign lo_next  = c_ext - half_ext;
    assign hi_next  = c_ext + half_ext;

    assign p_ext    = {{(DW-W){p3_reg[W-1]}}, p3_reg};
    assign dlo_next = {lo_reg[BW-1], lo_reg} - p_ext;
    assign dhi_next = p_ext - {hi_reg[BW-1], hi_reg};

    // The two excesses cannot both be positive since the low bound never passes the high one.
    assign below    = !dlo_reg[DW-1] && (|dlo_reg);
    assign above    = !dhi_reg[DW-1] && (|dhi_reg);
    assign e_sel    = below ? dlo_reg : (above ? dhi_reg : '0);
    assign e_wide   = {{(GAP_W-DW){1'b0}}, e_sel};
    assign sat_next = |e_wide[GAP_W-1:HALF_GAP_W];
    assign e_next   = e_wide[HALF_GAP_W-1:0];

    assign gap_next = sat_reg ? {GAP_W{1'b1}} : (GAP_W'(e_reg) * GAP_W'(e_reg));

    // Data registers move only when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            c1_reg   <= center;
            p1_reg   <= point;
            half_reg <= half_next;
            c2_reg   <= c1_reg;
            p2_reg   <= p1_reg;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            p3_reg   <= p2_reg;
            dlo_reg  <= dlo_next;
            dhi_reg  <= dhi_next;
            e_reg    <= e_next;
            sat_reg  <= sat_next;
            gap_reg  <= gap_next;
        end
    end

    assign gap = gap_reg;

endmodule

`default_nettype wire

// ----- rtl/asop_reduce.sv -----
// Saturating sum of the three axis gaps and the compare against radius squared.
// Also carries the radius square alongside the axis stages. Depends on asop_pkg.
`default_nettype none

module asop_reduce import asop_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             adv,
    input  wire logic [W-2:0]     radius,
    input  wire logic [GAP_W-1:0] gap_x,
    input  wire logic [GAP_W-1:0] gap_y,
    input  wire logic [GAP_W-1:0] gap_z,
    output logic                  overlaps,
    output logic      [GAP_W-1:0] squared_gap
);

    localparam int RW = W - 1;
    localparam int SW = 2 * RW;

    // Radius path: captured on entry, squared in the next stage, then delayed.
    logic [RW-1:0]    rad_reg;
    logic [SW-1:0]    rsq_next;
    logic [SW-1:0]    rsq_pipe_reg [RSQ_DEPTH];

    // First sum stage: x plus y, z delayed.
    logic [GAP_W:0]   s01_full;
    logic [GAP_W-1:0] s01_next;
    logic [GAP_W-1:0] s01_reg;
    logic [GAP_W-1:0] gz_reg;

    // Second sum stage: add z.
    logic [GAP_W:0]   sum_full;
    logic [GAP_W-1:0] sum_next;
    logic [GAP_W-1:0] sum_reg;

    // Output stage.
    logic             ovl_next;
    logic             ovl_reg;
    logic [GAP_W-1:0] gap_out_reg;

    assign rsq_next = SW'(rad_reg) * SW'(rad_reg);

    assign s01_full = {1'b0, gap_x} + {1'b0, gap_y};
    assign s01_next = s01_full[GAP_W] ? {GAP_W{1'b1}} : s01_full[GAP_W-1:0];

    assign sum_full = {1'b0, s01_reg} + {1'b0, gz_reg};
    assign sum_next = sum_full[GAP_W] ? {GAP_W{1'b1}} : sum_full[GAP_W-1:0];

    assign ovl_next = sum_reg <= GAP_W'(rsq_pipe_reg[RSQ_DEPTH-1]);

    // Data registers move only when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg         <= radius;
            rsq_pipe_reg[0] <= rsq_next;
            for (int i = 1; i < RSQ_DEPTH; i++)
            begin
                rsq_pipe_reg[i] <= rsq_pipe_reg[i-1];
            end
            s01_reg     <= s01_next;
            gz_reg      <= gap_z;
            sum_reg     <= sum_next;
            ovl_reg     <= ovl_next;
            gap_out_reg <= sum_reg;
        end
    end

    assign overlaps    = ovl_reg;
    assign squared_gap = gap_out_reg;

endmodule

`default_nettype wire

// ----- rtl/aabb_sphere_overlap_test.sv -----
// Top level of the box-sphere overlap test: three axis pipelines and the reduce stage.
// Depends on asop_pkg, asop_in_if, asop_out_if, asop_axis and asop_reduce.
`default_nettype none

// Tests an axis-aligned box against a sphere, all in signed Q16.16. Each beat on req
// carries one box (center, per-axis scale, base half size) and one sphere; each beat on
// rsp carries the squared distance from the sphere center to the box (Q32.32, saturated
// to all ones) and a flag that is set when that distance is at most radius squared.
// Only the low COORD_WIDTH bits of each coordinate are used. The block is a nine-stage
// pipeline: a beat is accepted every cycle while rsp is not stalled, and its result is held
// in the output register until rsp takes it. All stages share one advance enable, taken
// from the output register being empty or drained, so a stall on rsp holds every stage
// and req.ready falls in the same cycle.

module aabb_sphere_overlap_test import asop_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    asop_in_if.sink   req,
    asop_out_if.source rsp
);

    localparam int W = COORD_WIDTH;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [GAP_W-1:0]      gap_x;
    logic [GAP_W-1:0]      gap_y;
    logic [GAP_W-1:0]      gap_z;

    // The pipeline advances whenever the output register is free or being taken.
    assign adv       = !vld_reg[PIPE_DEPTH-1] || rsp.ready;
    assign req.ready = adv;
    assign vld_next  = {vld_reg[PIPE_DEPTH-2:0], req.valid};

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Per-axis pipelines.
    asop_axis #(.W(W)) u_axis_x (
        .clk    (clk),
        .adv    (adv),
        .center (req.box_center_x[W-1:0]),
        .scale  (req.box_scale_x[W-1:0]),
        .size   (req.box_half_size[W-1:0]),
        .point  (req.sphere_center_x[W-1:0]),
        .gap    (gap_x)
    );

    asop_axis #(.W(W)) u_axis_y (
        .clk    (clk),
        .adv    (adv),
        .center (req.box_center_y[W-1:0]),
        .scale  (req.box_scale_y[W-1:0]),
        .size   (req.box_half_size[W-1:0]),
        .point  (req.sphere_center_y[W-1:0]),
        .gap    (gap_y)
    );

    asop_axis #(.W(W)) u_axis_z (
        .clk    (clk),
        .adv    (adv),
        .center (req.box_center_z[W-1:0]),
        .scale  (req.box_scale_z[W-1:0]),
        .size   (req.box_half_size[W-1:0]),
        .point  (req.sphere_center_z[W-1:0]),
        .gap    (gap_z)
    );

    // Sum, compare and output register.
    asop_reduce #(.W(W)) u_reduce (
        .clk         (clk),
        .adv         (adv),
        .radius      (req.sphere_radius[W-2:0]),
        .gap_x       (gap_x),
        .gap_y       (gap_y),
        .gap_z       (gap_z),
        .overlaps    (rsp.overlaps),
        .squared_gap (rsp.squared_gap)
    );

    assign rsp.valid = vld_reg[PIPE_DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/asop_checker.sv -----
// Port-level checks for the box-sphere overlap test, bound to the top level.
// Depends on asop_pkg and aabb_sphere_overlap_test.
`default_nettype none

module asop_checker import asop_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_ready,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic             rsp_overlaps,
    input wire logic [GAP_W-1:0] rsp_squared_gap
);

    // A stalled result beat holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_squared_gap)
            && $stable(rsp_overlaps))
        else $error("result beat changed while stalled");

    // With the output register empty the block always takes a new beat.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input not ready while output is empty");

    // A saturated gap can never be within radius squared.
    a_sat_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_overlaps |-> rsp_squared_gap != {GAP_W{1'b1}})
        else $error("overlap flagged on a saturated gap");

    // A sphere center inside the box always overlaps.
    a_zero_gap_overlaps: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_squared_gap == '0 |-> rsp_overlaps)
        else $error("zero gap without overlap");

    // No result is shown while reset is applied.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

endmodule

bind aabb_sphere_overlap_test asop_checker u_asop_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_overlaps    (rsp.overlaps),
    .rsp_squared_gap (rsp.squared_gap)
);

`default_nettype wire

// ----- verif/asop_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the box-sphere overlap test: pair and result types, the gap predictor
// and the queue of expected results. Depends on asop_pkg for widths and fraction bits.

package asop_tb_pkg;
    import asop_pkg::*;

    localparam int COORD_W = COORD_WIDTH_DEF;

    // One box/sphere pair as it travels on the request channel.
    typedef struct packed {
        logic [FIELD_W-1:0]  box_center_x;
        logic [FIELD_W-1:0]  box_center_y;
        logic [FIELD_W-1:0]  box_center_z;
        logic [FIELD_W-1:0]  box_scale_x;
        logic [FIELD_W-1:0]  box_scale_y;
        logic [FIELD_W-1:0]  box_scale_z;
        logic [FIELD_W-1:0]  box_half_size;
        logic [FIELD_W-1:0]  sphere_center_x;
        logic [FIELD_W-1:0]  sphere_center_y;
        logic [FIELD_W-1:0]  sphere_center_z;
        logic [RADIUS_W-1:0] sphere_radius;
    } pair_t;

    // One result beat.
    typedef struct packed {
        logic             overlaps;
        logic [GAP_W-1:0] squared_gap;
    } gap_result_t;

    class overlap_scoreboard;
        gap_result_t pending_gaps[$];
        int          errors;
        int          pairs_sent;
        int          results_seen;
        int          hits;
        int          saturated;

        function new();
            errors       = 0;
            pairs_sent   = 0;
            results_seen = 0;
            hits         = 0;
            saturated    = 0;
        endfunction

        // Low COORD_W bits of a field, read as a two's-complement value.
        function longint to_coord(logic [FIELD_W-1:0] v);
            bit [63:0] u;
            u = 64'(v) & ((64'd1 << COORD_W) - 64'd1);
            if (u[COORD_W-1])
                u = u - (64'd1 << COORD_W);
            return longint'(u);
        endfunction

        // Squared excess of a point outside center +- |scale*size| (Q16.16 truncated).
        function bit [63:0] axis_excess_sq(longint center, longint scale, longint size,
                                           longint point);
            longint    prod;
            longint    half;
            longint    lo;
            longint    hi;
            bit [63:0] mag;
            bit [63:0] excess;
            prod = scale * size;
            mag  = (prod < 0) ? -prod : prod;
            half = longint'(mag >> FRAC_BITS);
            lo   = center - half;
            hi   = center + half;
            if (point < lo)
                excess = lo - point;
            else if (point > hi)
                excess = point - hi;
            else
                return '0;
            if (excess >= 64'h1_0000_0000)
                return '1;
            return excess * excess;
        endfunction

        // Saturating sum over the three axes, then the compare against radius squared.
        function gap_result_t predict_gap(pair_t p);
            gap_result_t       r;
            logic [FIELD_W-1:0] centers[3];
            logic [FIELD_W-1:0] scales[3];
            logic [FIELD_W-1:0] points[3];
            bit [63:0]         sum;
            bit [63:0]         term;
            bit [63:0]         next_sum;
            bit [63:0]         rad;
            centers = '{p.box_center_x, p.box_center_y, p.box_center_z};
            scales  = '{p.box_scale_x, p.box_scale_y, p.box_scale_z};
            points  = '{p.sphere_center_x, p.sphere_center_y, p.sphere_center_z};
            sum = '0;
            for (int a = 0; a < 3; a++)
            begin
                term = axis_excess_sq(to_coord(centers[a]), to_coord(scales[a]),
                                      to_coord(p.box_half_size), to_coord(points[a]));
                next_sum = sum + term;
                sum = (next_sum < sum) ? '1 : next_sum;
            end
            rad = 64'(p.sphere_radius) & ((64'd1 << (COORD_W - 1)) - 64'd1);
            r.overlaps    = (sum <= rad * rad);
            r.squared_gap = sum;
            return r;
        endfunction

        function void note_request(pair_t p);
            pending_gaps.push_back(predict_gap(p));
            pairs_sent++;
        endfunction

        // One line per mismatch, and the count for the verdict.
        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(logic overlaps, logic [GAP_W-1:0] squared_gap);
            gap_result_t want;
            results_seen++;
            if (pending_gaps.size() == 0)
            begin
                report($sformatf("result beat with nothing expected: overlaps=%0b gap=%h",
                                 overlaps, squared_gap));
                return;
            end
            want = pending_gaps.pop_front();
            if (overlaps !== want.overlaps)
                report($sformatf("overlaps=%0b, expected %0b (gap %h)",
                                 overlaps, want.overlaps, want.squared_gap));
            if (squared_gap !== want.squared_gap)
                report($sformatf("squared_gap=%h, expected %h",
                                 squared_gap, want.squared_gap));
            if (want.overlaps)
                hits++;
            if (want.squared_gap == '1)
                saturated++;
        endtask
    endclass

endpackage

// ----- verif/tb_aabb_sphere_overlap_test.sv -----
`timescale 1ns / 100ps
// Top-level testbench for aabb_sphere_overlap_test: drives box/sphere pairs, stalls the
// result side and checks every beat. Depends on asop_pkg, the RTL interfaces and asop_tb_pkg.

module tb_aabb_sphere_overlap_test;
    import asop_pkg::*;
    import asop_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] TWO     = 32'h0002_0000;
    localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
    localparam logic [31:0] NEG_MIN = 32'h8000_0000;

    logic clk;
    logic rst_n;

    asop_in_if  req_if ();
    asop_out_if rsp_if ();

    aabb_sphere_overlap_test dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    overlap_scoreboard sb = new();

    // Both sides run without gaps while this is set.
    bit steady;
    // Length of a long hold-off requested from the result side.
    int hold_cycles;
    int cycle_count;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, sb.pending_gaps.size());
        $display("== FAIL ==");
        $finish;
    end

    // Same box values on every axis; directed cases adjust single axes afterwards.
    function automatic pair_t box_pair(logic [31:0] center, logic [31:0] scale,
                                       logic [31:0] size, logic [31:0] point,
                                       logic [30:0] radius);
        pair_t p;
        p.box_center_x    = center;
        p.box_center_y    = center;
        p.box_center_z    = center;
        p.box_scale_x     = scale;
        p.box_scale_y     = scale;
        p.box_scale_z     = scale;
        p.box_half_size   = size;
        p.sphere_center_x = point;
        p.sphere_center_y = point;
        p.sphere_center_z = point;
        p.sphere_radius   = radius;
        return p;
    endfunction

    // Random pair: either fully random fields, or a sphere placed near a modest box
    // so that both outcomes of the overlap flag turn up often.
    function automatic pair_t draw_pair(bit wide);
        pair_t       p;
        logic [31:0] bc[3];
        logic [31:0] sc[3];
        logic [31:0] sp[3];
        for (int a = 0; a < 3; a++)
        begin
            if (wide)
            begin
                bc[a] = $urandom();
                sc[a] = $urandom();
                sp[a] = $urandom();
            end
            else
            begin
                bc[a] = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                sc[a] = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                sp[a] = bc[a] + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            end
        end
        p.box_center_x    = bc[0];
        p.box_center_y    = bc[1];
        p.box_center_z    = bc[2];
        p.box_scale_x     = sc[0];
        p.box_scale_y     = sc[1];
        p.box_scale_z     = sc[2];
        p.sphere_center_x = sp[0];
        p.sphere_center_y = sp[1];
        p.sphere_center_z = sp[2];
        p.box_half_size   = wide ? $urandom() : $urandom_range(0, 32'h0004_0000) - ONE;
        p.sphere_radius   = wide ? 31'($urandom()) : 31'($urandom_range(0, 32'h0006_0000));
        return p;
    endfunction

    // Offer one pair after a random gap and hold it until the block takes the beat.
    task automatic send_pair(input pair_t p);
        int unsigned lazy;
        lazy = steady ? 0 : $urandom_range(0, 7);
        if (lazy > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (lazy) @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.box_center_x    <= p.box_center_x;
        req_if.box_center_y    <= p.box_center_y;
        req_if.box_center_z    <= p.box_center_z;
        req_if.box_scale_x     <= p.box_scale_x;
        req_if.box_scale_y     <= p.box_scale_y;
        req_if.box_scale_z     <= p.box_scale_z;
        req_if.box_half_size   <= p.box_half_size;
        req_if.sphere_center_x <= p.sphere_center_x;
        req_if.sphere_center_y <= p.sphere_center_y;
        req_if.sphere_center_z <= p.sphere_center_z;
        req_if.sphere_radius   <= p.sphere_radius;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(p);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_pair(draw_pair($urandom_range(0, 9) < 3));
    endtask

    // Result side: random stalls, a long hold-off on request, then take one beat.
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            sb.check_result(rsp_if.overlaps, rsp_if.squared_gap);
        end
    end

    // Reset, directed corners, random phases, then drain and verdict.
    initial
    begin
        pair_t p;
        steady      = 1'b0;
        hold_cycles = 0;
        rst_n                  <= 1'b0;
        rsp_if.ready           <= 1'b0;
        req_if.valid           <= 1'b0;
        req_if.box_center_x    <= '0;
        req_if.box_center_y    <= '0;
        req_if.box_center_z    <= '0;
        req_if.box_scale_x     <= '0;
        req_if.box_scale_y     <= '0;
        req_if.box_scale_z     <= '0;
        req_if.box_half_size   <= '0;
        req_if.sphere_center_x <= '0;
        req_if.sphere_center_y <= '0;
        req_if.sphere_center_z <= '0;
        req_if.sphere_radius   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Degenerate box at the origin with zero radius: gap zero still overlaps.
        send_pair(box_pair('0, '0, '0, '0, '0));
        // Center inside on every axis.
        send_pair(box_pair('0, ONE, TWO, ONE, '0));
        // Exactly on the max face.
        send_pair(box_pair('0, ONE, TWO, TWO, '0));
        // One lsb outside on x, against radius one lsb and radius zero.
        p = box_pair('0, ONE, TWO, '0, 31'd1);
        p.sphere_center_x = TWO + 1;
        send_pair(p);
        p.sphere_radius = '0;
        send_pair(p);
        // Gap equal to radius squared, outside the max face on x.
        p = box_pair('0, ONE, TWO, '0, 31'h0003_0000);
        p.sphere_center_x = 32'h0005_0000;
        send_pair(p);
        // Below the min face on y only.
        p = box_pair('0, ONE, TWO, '0, 31'h0001_0000);
        p.sphere_center_y = 32'hfffc_0000;
        send_pair(p);
        // Negative scale, negative size, and both negative.
        send_pair(box_pair('0, -ONE, TWO, 32'hfffe_8000, '0));
        send_pair(box_pair('0, ONE, -TWO, 32'h0001_8000, '0));
        send_pair(box_pair(ONE, -ONE, -TWO, 32'h0004_0000, 31'h0001_0000));
        // Half-extents far wider than 32 bits, then a half-extent of one at the max center, sphere at the min.
        send_pair(box_pair('0, POS_MAX, POS_MAX, POS_MAX, '0));
        send_pair(box_pair('0, NEG_MIN, NEG_MIN, NEG_MIN, '0));
        send_pair(box_pair(POS_MAX, ONE, ONE, NEG_MIN, 31'h7fff_ffff));
        // Largest single-axis excess without saturation.
        p = box_pair('0, '0, '0, '0, 31'h7fff_ffff);
        p.box_center_x = NEG_MIN;
        p.sphere_center_x = POS_MAX;
        send_pair(p);
        // Two and three axes at the largest excess: the sum saturates.
        p.box_center_y = POS_MAX;
        p.sphere_center_y = NEG_MIN;
        send_pair(p);
        send_pair(box_pair(POS_MAX, '0, '0, NEG_MIN, 31'h7fff_ffff));
        send_pair(box_pair(NEG_MIN, '0, POS_MAX, POS_MAX, '0));
        // Largest radius against a moderate gap.
        send_pair(box_pair('0, ONE, ONE, 32'h4000_0000, 31'h7fff_ffff));
        // All-ones, all-max, all-min and alternating bit patterns.
        send_pair(box_pair('1, '1, '1, '1, '1));
        send_pair(box_pair(POS_MAX, POS_MAX, POS_MAX, POS_MAX, 31'h7fff_ffff));
        send_pair(box_pair(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, '0));
        send_pair(box_pair(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                           31'h2aaa_aaaa));
        send_pair(box_pair(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                           31'h5555_5555));
        // Zero scale: the box is a point, sphere centered on it.
        send_pair(box_pair(32'h1234_5678, '0, POS_MAX, 32'h1234_5678, '0));

        send_random(300);

        // Long hold-off on results while pairs keep coming, so the pipeline backs up.
        steady = 1'b1;
        hold_cycles = 120;
        send_random(60);
        steady = 1'b0;

        // Stop offering until every outstanding result has come back.
        req_if.valid <= 1'b0;
        while (sb.pending_gaps.size() != 0)
            @(posedge clk);

        // Back-to-back on both sides.
        steady = 1'b1;
        send_random(200);
        steady = 1'b0;

        send_random(365);

        req_if.valid <= 1'b0;
        while (sb.pending_gaps.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH + 10) @(posedge clk);

        $display("Checked %0d result beats for %0d pairs: %0d overlapping, %0d saturated.",
                 sb.results_seen, sb.pairs_sent, sb.hits, sb.saturated);
        $display("Run covered corner boxes, random pairs, a long result stall and a drain.");
        if (sb.errors == 0 && sb.pending_gaps.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
